// ----- src/catalog_slot_free_list_assert.svh -----
// ---------------------------------------------------------------------------
// catalog_slot_free_list_assert.svh
// Assertion macros used by the free list port checker.
// ---------------------------------------------------------------------------
`ifndef CATALOG_SLOT_FREE_LIST_ASSERT_SVH
`define CATALOG_SLOT_FREE_LIST_ASSERT_SVH

// Same-cycle implication, sampled on clock, off during reset
`define CSLOT_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("free list assertion failed");

// Next-cycle implication, sampled on clock, off during reset
`define CSLOT_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("free list assertion failed");

`endif

// ----- src/cslot_pkg.sv -----
// ---------------------------------------------------------------------------
// cslot_pkg
// Shared types and codes for the catalogue slot free list.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package cslot_pkg;

   // Field widths fixed by the port definition
   localparam int SLOT_W   = 11;
   localparam int ROW_W    = 7;
   localparam int STATUS_W = 2;

   // Request codes
   typedef enum logic {
      ACT_ALLOC   = 1'b0,
      ACT_RELEASE = 1'b1
   } action_type;

   // Response status codes
   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_RANGE = 2'd2
   } status_type;

   // Sequencer states
   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } state_type;

   // Decoded request, held while the link memory read is in flight
   typedef struct packed {
      logic              is_free;
      status_type        status;
      logic              pop;
      logic [SLOT_W-1:0] target;
   } op_type;

endpackage

// ----- src/cslot_ram.sv -----
// ---------------------------------------------------------------------------
// cslot_ram
// Generic single-write, single-read RAM with a registered read port.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module cslot_ram #(
   parameter int WIDTH = 11,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port, holds between reads
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/catalog_slot_free_list.sv -----
// ---------------------------------------------------------------------------
// catalog_slot_free_list
// Slot allocator with a last-in first-out free list kept in a link memory.
// ---------------------------------------------------------------------------
//  Channel   Ports    Direction  Beat carries
//  request   req_*    in         action, slot_in
//  response  rsp_*    out        slot_out, page_out, row_out, live_count, status
//
//  Each request passes through accept (link read issued at the head slot),
//  then commit, which uses the link memory's registered read data.
//  Commit waits while a previous response is held by rsp_stall.
//  A new request is accepted while the last response waits to be taken.
//  Reset is synchronous; the link memory needs no clearing pass.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module catalog_slot_free_list
   import cslot_pkg::*;
#(
   parameter int MAX_SLOTS      = 1024,
   parameter int SLOTS_PER_PAGE = 10
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_action,
   input  logic [SLOT_W-1:0]   req_slot_in,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [SLOT_W-1:0]   rsp_slot_out,
   output logic [SLOT_W-1:0]   rsp_page_out,
   output logic [ROW_W-1:0]    rsp_row_out,
   output logic [SLOT_W-1:0]   rsp_live_count,
   output logic [STATUS_W-1:0] rsp_status
);

   localparam int AW      = $clog2(MAX_SLOTS);
   localparam int CNT_W   = $clog2(MAX_SLOTS + 1);
   // Reciprocal for the page split: floor(2^K / per_page)
   localparam int K       = 18;
   localparam int RECIP_W = K + 1;
   localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((1 << K) / SLOTS_PER_PAGE);
   localparam int DIV_W   = 8;
   localparam logic [DIV_W-1:0] DIV_D = DIV_W'(SLOTS_PER_PAGE);
   localparam int PROD_W  = SLOT_W + RECIP_W;
   localparam int QD_W    = SLOT_W + DIV_W;

   state_type state_ff, state_in;
   logic [CNT_W-1:0]  used_ff, used_in;
   logic [SLOT_W-1:0] head_ff, head_in;
   op_type            op_ff, op_in;
   logic [SLOT_W-1:0] xm1_ff, xm1_in;
   logic [SLOT_W-1:0] quot_ff, quot_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [SLOT_W-1:0]   slot_out_ff, slot_out_in;
   logic [SLOT_W-1:0]   page_out_ff, page_out_in;
   logic [ROW_W-1:0]    row_out_ff, row_out_in;
   logic [SLOT_W-1:0]   live_ff, live_in;
   logic [STATUS_W-1:0] status_ff, status_in;

   logic              accept, commit, out_free;
   logic              full, bad_slot;
   logic [SLOT_W-1:0] fresh;
   logic [PROD_W-1:0] prod;
   logic [QD_W-1:0]   qd, rem_wide;
   logic [DIV_W-1:0]  rem0;
   logic [SLOT_W-1:0] quot;
   logic [DIV_W-1:0]  rem;

   logic              wr_en;
   logic [AW-1:0]     wr_addr;
   logic [SLOT_W-1:0] wr_data;
   logic [SLOT_W-1:0] link_rd;

   // Link memory: one entry per slot, holds the next free slot
   cslot_ram #(
      .WIDTH (SLOT_W),
      .DEPTH (MAX_SLOTS)
   ) u_link (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (accept),
      .rd_addr (AW'(head_ff - SLOT_W'(1))),
      .rd_data (link_rd)
   );

   assign accept   = req_valid && (state_ff == ST_IDLE);
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign commit   = (state_ff == ST_EXEC) && out_free;

   // Request decode at accept
   always_comb begin
      full     = (used_ff >= CNT_W'(MAX_SLOTS));
      bad_slot = (req_slot_in == '0) || (32'(req_slot_in) > MAX_SLOTS) ||
                 (used_ff == '0);
      fresh    = SLOT_W'(used_ff + CNT_W'(1));
      op_in.is_free = (req_action == ACT_RELEASE);
      op_in.status  = STATUS_OK;
      op_in.pop     = 1'b0;
      op_in.target  = '0;
      if (req_action == ACT_ALLOC) begin
         if (full) begin
            op_in.status = STATUS_FULL;
         end else if (head_ff != '0) begin
            op_in.pop    = 1'b1;
            op_in.target = head_ff;
         end else begin
            op_in.target = fresh;
         end
      end else begin
         if (bad_slot) begin
            op_in.status = STATUS_RANGE;
         end else begin
            op_in.target = req_slot_in;
         end
      end
      // First half of the page split: quotient estimate, low by at most one
      xm1_in  = op_in.target - SLOT_W'(1);
      prod    = PROD_W'(xm1_in) * PROD_W'(RECIP);
      quot_in = prod[K +: SLOT_W];
   end

   // Second half of the page split: remainder and one correction step
   always_comb begin
      qd       = QD_W'(quot_ff) * QD_W'(DIV_D);
      rem_wide = QD_W'(xm1_ff) - qd;
      rem0     = rem_wide[DIV_W-1:0];
      if (rem0 >= DIV_D) begin
         quot = quot_ff + SLOT_W'(1);
         rem  = rem0 - DIV_D;
      end else begin
         quot = quot_ff;
         rem  = rem0;
      end
   end

   // Sequencer, state update, link write and response load
   always_comb begin
      state_in     = state_ff;
      used_in      = used_ff;
      head_in      = head_ff;
      wr_en        = 1'b0;
      wr_addr      = AW'(op_ff.target - SLOT_W'(1));
      wr_data      = '0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      slot_out_in  = slot_out_ff;
      page_out_in  = page_out_ff;
      row_out_in   = row_out_ff;
      live_in      = live_ff;
      status_in    = status_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (commit) begin
               state_in = ST_IDLE;
               if (op_ff.status == STATUS_OK) begin
                  wr_en = 1'b1;
                  if (op_ff.is_free) begin
                     wr_data = head_ff;
                     head_in = op_ff.target;
                     used_in = used_ff - CNT_W'(1);
                  end else begin
                     used_in = used_ff + CNT_W'(1);
                     if (op_ff.pop) begin
                        head_in = link_rd;
                     end
                  end
                  slot_out_in = op_ff.target;
                  page_out_in = quot + SLOT_W'(2);
                  row_out_in  = ROW_W'(rem) + ROW_W'(1);
               end else begin
                  slot_out_in = '0;
                  page_out_in = '0;
                  row_out_in  = '0;
               end
               rsp_valid_in = 1'b1;
               live_in      = SLOT_W'(used_in);
               status_in    = op_ff.status;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         used_ff      <= '0;
         head_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         head_ff      <= head_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff   <= op_in;
         xm1_ff  <= xm1_in;
         quot_ff <= quot_in;
      end
      slot_out_ff <= slot_out_in;
      page_out_ff <= page_out_in;
      row_out_ff  <= row_out_in;
      live_ff     <= live_in;
      status_ff   <= status_in;
   end

   assign req_stall      = (state_ff != ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_slot_out   = slot_out_ff;
   assign rsp_page_out   = page_out_ff;
   assign rsp_row_out    = row_out_ff;
   assign rsp_live_count = live_ff;
   assign rsp_status     = status_ff;

endmodule

// ----- src/cslot_checker.sv -----
// ---------------------------------------------------------------------------
// cslot_port_checker
// Port-level checks on the free list responses, bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "catalog_slot_free_list_assert.svh"

module cslot_port_checker
   import cslot_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                rsp_valid,
   input logic                rsp_stall,
   input logic [SLOT_W-1:0]   rsp_slot_out,
   input logic [SLOT_W-1:0]   rsp_page_out,
   input logic [ROW_W-1:0]    rsp_row_out,
   input logic [STATUS_W-1:0] rsp_status
);

   logic ok_beat, err_beat, loc_set, loc_clear, code_known;
   logic [2*SLOT_W+ROW_W+STATUS_W-1:0] beat_key;

   // Beat classification and location terms
   assign ok_beat    = rsp_valid && (rsp_status == STATUS_OK);
   assign err_beat   = rsp_valid && (rsp_status != STATUS_OK);
   assign loc_set    = (rsp_slot_out != '0) && (rsp_row_out != '0) &&
                       (rsp_page_out >= SLOT_W'(2));
   assign loc_clear  = (rsp_slot_out == '0) && (rsp_page_out == '0) &&
                       (rsp_row_out == '0);
   assign code_known = (rsp_status == STATUS_OK) || (rsp_status == STATUS_FULL) ||
                       (rsp_status == STATUS_RANGE);
   assign beat_key   = {rsp_slot_out, rsp_page_out, rsp_row_out, rsp_status};

   // A good beat names a real slot with a real location
   `CSLOT_ASSERT_NOW(a_ok_slot, ok_beat, loc_set)

   // An error beat carries no slot or location
   `CSLOT_ASSERT_NOW(a_err_clear, err_beat, loc_clear)

   // Only defined status codes appear
   `CSLOT_ASSERT_NOW(a_status_code, rsp_valid, code_known)

   // A stalled response beat holds
   `CSLOT_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(beat_key))

endmodule

bind catalog_slot_free_list cslot_port_checker u_cslot_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_valid),
   .rsp_stall    (rsp_stall),
   .rsp_slot_out (rsp_slot_out),
   .rsp_page_out (rsp_page_out),
   .rsp_row_out  (rsp_row_out),
   .rsp_status   (rsp_status)
);
